// File: rtl/lsdw_pkg.sv
// ----------------------------------------------------------------------------
// lsdw_pkg
// Shared constants and types of the LCD shadow delta writer: screen geometry,
// display command codes, register map and the structs passed between modules.
// ----------------------------------------------------------------------------
package lsdw_pkg;

    // Screen geometry
    localparam int COLUMNS      = 20;
    localparam int LINES        = 4;
    localparam int SHADOW_DEPTH = COLUMNS * LINES;
    localparam int IDX_W        = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;

    // Field widths
    localparam int FIELD_W = 8;
    localparam int ADDR_W  = 7;
    localparam int CALC_W  = 16;

    // Display controller codes
    localparam logic [FIELD_W-1:0] SPACE_CODE  = 8'h20;
    localparam logic [FIELD_W-1:0] SET_ADDRESS = 8'h80;

    // Register map (word addressed through paddr[APB_ADDR_W-1:2])
    localparam int               APB_ADDR_W    = 3;
    localparam int               APB_DATA_W    = 32;
    localparam logic             REG_LINE_STRIDE = 1'b0;
    localparam logic [ADDR_W-1:0] STRIDE_RESET = 7'd32;

    // Shadow store write transaction
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [FIELD_W-1:0] data;
    } shadow_wr_t;

    // One result for the display controller
    typedef struct packed {
        logic               is_data;
        logic [FIELD_W-1:0] lcd_byte;
        logic               last;
    } result_t;

endpackage

// File: rtl/lsdw_apb_regs.sv
// ----------------------------------------------------------------------------
// lsdw_apb_regs
// APB register block holding the line stride of the display address map.
// ----------------------------------------------------------------------------
module lsdw_apb_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lsdw_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lsdw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lsdw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic [lsdw_pkg::ADDR_W-1:0]          line_stride
);
    import lsdw_pkg::*;

    logic [ADDR_W-1:0] stride_reg;
    logic [ADDR_W-1:0] stride_next;
    logic              wr_strobe;

    assign pready      = 1'b1;
    assign wr_strobe   = psel & penable & pwrite & pready;
    assign line_stride = stride_reg;

    // Decode the write
    always_comb begin
        stride_next = stride_reg;
        if (wr_strobe) begin
            unique case (paddr[APB_ADDR_W-1:2])
                REG_LINE_STRIDE: stride_next = pwdata[ADDR_W-1:0];
                default:         stride_next = stride_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg <= STRIDE_RESET;
        end else begin
            stride_reg <= stride_next;
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[APB_ADDR_W-1:2])
            REG_LINE_STRIDE: prdata = {{(APB_DATA_W-ADDR_W){1'b0}}, stride_reg};
            default:         prdata = '0;
        endcase
    end

endmodule

// File: rtl/lsdw_shadow_mem.sv
// ----------------------------------------------------------------------------
// lsdw_shadow_mem
// Screen shadow store: synchronous memory with registered read, per-entry valid bits
// (unwritten entries read as a space) and forwarding of a same-edge write.
// ----------------------------------------------------------------------------
module lsdw_shadow_mem (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           rd_en,
    input  logic [lsdw_pkg::IDX_W-1:0]     rd_idx,
    output logic [lsdw_pkg::FIELD_W-1:0]   rd_data,
    input  lsdw_pkg::shadow_wr_t           wr
);
    import lsdw_pkg::*;

    logic [FIELD_W-1:0]      mem [SHADOW_DEPTH];
    logic [SHADOW_DEPTH-1:0] valid_reg;
    logic [FIELD_W-1:0]      mem_q_reg;
    logic                    valid_q_reg;
    logic                    fwd_hit_reg;
    logic [FIELD_W-1:0]      fwd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx] <= wr.data;
        end
    end

    // Valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    // Registered read; catch a write to the same entry on the same edge
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_q_reg    <= mem[rd_idx];
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_q_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            valid_q_reg <= valid_reg[rd_idx];
            fwd_hit_reg <= wr.en && (wr.idx == rd_idx);
        end
    end

    // Resolve the entry value
    assign rd_data = fwd_hit_reg ? fwd_data_reg
                   : (valid_q_reg ? mem_q_reg : SPACE_CODE);

endmodule

// File: rtl/lsdw_result_buf.sv
// ----------------------------------------------------------------------------
// lsdw_result_buf
// Two-entry result buffer that drives the output stream: loads the one or two
// results of an item at once and hands them out one per transaction.
// ----------------------------------------------------------------------------
module lsdw_result_buf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic                          load_two,
    input  lsdw_pkg::result_t             res_first,
    input  lsdw_pkg::result_t             res_second,
    output logic                          can_load,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsdw_pkg::FIELD_W-1:0]  m_tdata,   // [7:0] lcd_byte
    output logic [0:0]                    m_tuser,   // [0] is_data
    output logic                          m_tlast
);
    import lsdw_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    head_reg;
    result_t    head_next;
    result_t    tail_reg;
    result_t    tail_next;
    logic       pop;

    assign pop      = m_tvalid & m_tready;
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    // Advance the buffer
    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (pop) begin
            cnt_next  = cnt_reg - 2'd1;
            head_next = tail_reg;
        end
        if (load) begin
            if (load_two) begin
                cnt_next  = 2'd2;
                head_next = res_first;
                tail_next = res_second;
            end else begin
                cnt_next  = 2'd1;
                head_next = res_first;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_tvalid   = (cnt_reg != 2'd0);
    assign m_tdata    = head_reg.lcd_byte;
    assign m_tuser[0] = head_reg.is_data;
    assign m_tlast    = head_reg.last;

    // Checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_cmd_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (!m_tlast && cnt_reg == 2'd2))
        else $error("command byte without data byte behind it");

    a_data_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && m_tready) |=> (m_tvalid && m_tuser[0] && m_tlast))
        else $error("data byte did not follow command byte");

endmodule

// File: rtl/lcd_shadow_delta_writer.sv
// ----------------------------------------------------------------------------
// lcd_shadow_delta_writer
// Sends to a character LCD only the characters that differ from a shadow copy
// of the screen, each run of changed characters opened by a set-address
// command.
// ----------------------------------------------------------------------------
// Each character transaction carries column, line and code; end_of_write
// rides on s_tlast. The block accepts one character per cycle and gives out
// one byte per cycle while the output stream is not stalled; a changed
// character waits in the compare stage until the result buffer can take its
// bytes. A changed character that opens a run costs two output transactions
// (command on m_tuser = 0, then data on m_tuser = 1), a changed character
// inside a run costs one, and a matching or off-screen character costs none,
// so sustained rate is set by the output stream. The first byte of a
// character passes the shadow read and compare stage registers, loaded at
// the accepting edge, and then the result buffer, which the compare loads
// once the buffer can take the results. The shadow is a single-port-write,
// one-read memory; a character following directly behind a write to the same
// place sees the new value through a forwarding path. The shadow reads as all
// spaces right after reset with no clearing pass. line_stride (register 0)
// must only be written while the block is idle.
// ----------------------------------------------------------------------------
module lcd_shadow_delta_writer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // APB configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lsdw_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lsdw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lsdw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    // character stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [3*lsdw_pkg::FIELD_W-1:0]       s_tdata,  // [7:0] column, [15:8] line,
                                                           // [23:16] char_code
    input  logic                                 s_tlast,  // end_of_write
    // display byte stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lsdw_pkg::FIELD_W-1:0]         m_tdata,  // [7:0] lcd_byte
    output logic [0:0]                           m_tuser,  // [0] is_data
    output logic                                 m_tlast   // last
);
    import lsdw_pkg::*;

    logic [ADDR_W-1:0]  line_stride;
    logic [FIELD_W-1:0] in_column;
    logic [FIELD_W-1:0] in_line;
    logic [FIELD_W-1:0] in_code;
    logic               in_accept;
    logic               in_range;
    logic [CALC_W-1:0]  idx_full;
    logic [CALC_W-1:0]  addr_full;

    logic               s1_valid_reg;
    logic               s1_range_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [FIELD_W-1:0] s1_code_reg;
    logic               s1_end_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic               run_open_reg;
    logic               run_open_next;

    logic [FIELD_W-1:0] shadow_val;
    logic               differ;
    logic               need_cmd;
    logic               s1_fire;
    logic               can_load;
    shadow_wr_t         shadow_wr;
    result_t            res_first;
    result_t            res_second;

    // Configuration registers
    lsdw_apb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .line_stride (line_stride)
    );

    // Unpack the input and compute shadow index and display address
    assign in_column = s_tdata[FIELD_W-1:0];
    assign in_line   = s_tdata[2*FIELD_W-1:FIELD_W];
    assign in_code   = s_tdata[3*FIELD_W-1:2*FIELD_W];
    assign in_accept = s_tvalid & s_tready;
    assign in_range  = ({8'd0, in_column} < CALC_W'(COLUMNS))
                    && ({8'd0, in_line} < CALC_W'(LINES));
    assign idx_full  = CALC_W'(in_line) * CALC_W'(COLUMNS) + CALC_W'(in_column);
    assign addr_full = CALC_W'(in_line) * CALC_W'(line_stride) + CALC_W'(in_column);

    // Take a new character while the compare stage is empty or moving on
    assign s_tready = !s1_valid_reg || s1_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_range_reg <= in_range;
            s1_idx_reg   <= idx_full[IDX_W-1:0];
            s1_code_reg  <= in_code;
            s1_end_reg   <= s_tlast;
            s1_addr_reg  <= addr_full[ADDR_W-1:0];
        end
    end

    // Shadow store
    lsdw_shadow_mem u_shadow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_accept),
        .rd_idx  (idx_full[IDX_W-1:0]),
        .rd_data (shadow_val),
        .wr      (shadow_wr)
    );

    // Compare and decide the results
    assign differ   = s1_range_reg && (shadow_val != s1_code_reg);
    assign need_cmd = differ && !run_open_reg;
    assign s1_fire  = s1_valid_reg && (!differ || can_load);

    assign shadow_wr.en   = s1_fire && differ;
    assign shadow_wr.idx  = s1_idx_reg;
    assign shadow_wr.data = s1_code_reg;

    always_comb begin
        res_first  = '{is_data: 1'b1, lcd_byte: s1_code_reg, last: 1'b1};
        res_second = '{is_data: 1'b1, lcd_byte: s1_code_reg, last: 1'b1};
        if (need_cmd) begin
            res_first = '{is_data: 1'b0, lcd_byte: SET_ADDRESS | {1'b0, s1_addr_reg},
                          last: 1'b0};
        end
    end

    // Track the open address run
    always_comb begin
        run_open_next = run_open_reg;
        if (s1_fire) begin
            run_open_next = differ && !s1_end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg <= 1'b0;
        end else begin
            run_open_reg <= run_open_next;
        end
    end

    // Output buffer
    lsdw_result_buf u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (shadow_wr.en),
        .load_two   (need_cmd),
        .res_first  (res_first),
        .res_second (res_second),
        .can_load   (can_load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // Checks
    a_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_end_reg) |=> !run_open_reg)
        else $error("address run still open after end of write");

    a_skip_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && !differ) |=> !run_open_reg)
        else $error("address run open after skipped character");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        shadow_wr.en |-> (s1_range_reg && s1_valid_reg))
        else $error("shadow written for an off-screen character");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the LCD shadow delta writer. A short table of characters checks
// run opening, skipping and dropping after reset. Random screen writes follow
// under several line strides and flow-control patterns. Every display byte is
// compared with the table's bytes or a behavioral copy of the shadow screen kept here.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsdw_pkg::*;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_DATA = 1'b1;
    localparam logic [APB_ADDR_W-1:0] STRIDE_ADDR = APB_ADDR_W'(4 * int'(REG_LINE_STRIDE));
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam result_t NO_BYTE = '0;

    // One character of a screen write
    typedef struct packed {
        logic [FIELD_W-1:0] column;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] code;
        logic               eow;
    } char_item_t;

    // Directed row; n_bytes < 0 leaves the expectation to the predictor
    typedef struct {
        char_item_t ch;
        int         n_bytes;
        result_t    bytes [2];
    } script_row_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [3*FIELD_W-1:0]  s_tdata  = '0;  // [7:0] column, [15:8] line, [23:16] char_code
    logic                  s_tlast  = 1'b0; // end_of_write
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [FIELD_W-1:0]    m_tdata;         // [7:0] lcd_byte
    logic [0:0]            m_tuser;         // [0] is_data
    logic                  m_tlast;

    // Predictor state
    logic [FIELD_W-1:0] shadow_copy [SHADOW_DEPTH];
    logic               run_is_open = 1'b0;
    logic [ADDR_W-1:0]  stride_cfg  = STRIDE_RESET;

    result_t lcd_bytes_due [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    bit      hold_req       = 1'b0;

    // After reset: opening, continuing and closing runs, off-screen drops, extremes
    script_row_t script [16] = '{
        '{'{8'd0,   8'd0,   8'h41, 1'b0}, 2, '{'{KIND_CMD, 8'h80, 1'b0}, '{KIND_DATA, 8'h41, 1'b1}}},
        '{'{8'd1,   8'd0,   8'h42, 1'b0}, 1, '{'{KIND_DATA, 8'h42, 1'b1}, NO_BYTE}},
        '{'{8'd2,   8'd0,   8'h20, 1'b0}, 0, '{NO_BYTE, NO_BYTE}},
        '{'{8'd3,   8'd0,   8'h43, 1'b1}, 2, '{'{KIND_CMD, 8'h83, 1'b0}, '{KIND_DATA, 8'h43, 1'b1}}},
        '{'{8'd19,  8'd3,   8'hFF, 1'b0}, 2, '{'{KIND_CMD, 8'hF3, 1'b0}, '{KIND_DATA, 8'hFF, 1'b1}}},
        '{'{8'd20,  8'd0,   8'h00, 1'b0}, 0, '{NO_BYTE, NO_BYTE}},
        '{'{8'd0,   8'd4,   8'h00, 1'b0}, 0, '{NO_BYTE, NO_BYTE}},
        '{'{8'd255, 8'd255, 8'hFF, 1'b1}, 0, '{NO_BYTE, NO_BYTE}},
        '{'{8'd0,   8'd3,   8'h00, 1'b0}, 2, '{'{KIND_CMD, 8'hE0, 1'b0}, '{KIND_DATA, 8'h00, 1'b1}}},
        '{'{8'd1,   8'd3,   8'h00, 1'b0}, 1, '{'{KIND_DATA, 8'h00, 1'b1}, NO_BYTE}},
        '{'{8'd0,   8'd0,   8'h41, 1'b1}, 0, '{NO_BYTE, NO_BYTE}},
        '{'{8'd5,   8'd2,   8'h55, 1'b1}, 2, '{'{KIND_CMD, 8'hC5, 1'b0}, '{KIND_DATA, 8'h55, 1'b1}}},
        '{'{8'd5,   8'd2,   8'hAA, 1'b0}, -1, '{NO_BYTE, NO_BYTE}},
        '{'{8'd5,   8'd2,   8'hAA, 1'b0}, -1, '{NO_BYTE, NO_BYTE}},
        '{'{8'd6,   8'd2,   8'h7F, 1'b1}, -1, '{NO_BYTE, NO_BYTE}},
        '{'{8'd7,   8'd1,   8'h80, 1'b1}, -1, '{NO_BYTE, NO_BYTE}}
    };

    lcd_shadow_delta_writer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lcd_shadow_delta_writer test failed");
            $finish;
        end
    end

    // Work out the display bytes of one character and advance the shadow copy
    function automatic int predict_char_bytes(input char_item_t c, output result_t b [2]);
        int                idx;
        int                n;
        logic [ADDR_W-1:0] addr;
        n = 0;
        b[0] = NO_BYTE;
        b[1] = NO_BYTE;
        if (c.column >= COLUMNS || c.line >= LINES) begin
            run_is_open = 1'b0;
        end else begin
            idx = int'(c.line) * COLUMNS + int'(c.column);
            if (shadow_copy[idx] == c.code) begin
                run_is_open = 1'b0;
            end else begin
                if (!run_is_open) begin
                    addr = ADDR_W'(int'(c.line) * int'(stride_cfg) + int'(c.column));
                    b[n] = '{KIND_CMD, SET_ADDRESS | {1'b0, addr}, 1'b0};
                    n++;
                    run_is_open = 1'b1;
                end
                b[n] = '{KIND_DATA, c.code, 1'b0};
                n++;
                shadow_copy[idx] = c.code;
            end
        end
        if (n > 0) b[n-1].last = 1'b1;
        if (c.eow) run_is_open = 1'b0;
        return n;
    endfunction

    // Offer one character, queue its bytes, return at the accepting edge
    task automatic send_char(input char_item_t c, input int n_typed, input result_t typed [2]);
        result_t b [2];
        int      n;
        n = predict_char_bytes(c, b);
        if (n_typed >= 0) begin
            n = n_typed;
            b = typed;
        end
        for (int i = 0; i < n; i++) lcd_bytes_due.push_back(b[i]);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.code, c.line, c.column};
        s_tlast  <= c.eow;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid, drain every expected byte, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (lcd_bytes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $error("prdata: expected %h, got %h", want, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write line_stride, read it back, track it in the predictor
    task automatic set_stride(input logic [ADDR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STRIDE_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        stride_cfg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        apb_read(STRIDE_ADDR, APB_DATA_W'(value));
    endtask

    // Mostly well-formed screen writes with random content, some noise
    task automatic random_writes(input int n_chars);
        char_item_t c;
        result_t    unused [2];
        int         sent;
        int         start;
        int         len;
        logic [7:0] line_sel;
        sent = 0;
        unused[0] = NO_BYTE;
        unused[1] = NO_BYTE;
        while (sent < n_chars) begin
            if ($urandom_range(99) < 15) begin
                c.column = $urandom_range(1) ? 8'($urandom_range(COLUMNS - 1)) : 8'($urandom);
                c.line   = $urandom_range(1) ? 8'($urandom_range(LINES - 1)) : 8'($urandom);
                c.code   = 8'($urandom);
                c.eow    = 1'($urandom_range(1));
                send_char(c, -1, unused);
                if (c.column < COLUMNS && c.line < LINES) sent++;
            end else begin
                line_sel = 8'($urandom_range(LINES - 1));
                start    = $urandom_range(COLUMNS - 1);
                len      = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    c.column = 8'(start + k);
                    c.line   = line_sel;
                    // small alphabet so that many characters repeat the screen
                    c.code   = ($urandom_range(3) == 0) ? 8'($urandom)
                                                        : 8'h20 + 8'($urandom_range(3));
                    c.eow    = (k == len - 1);
                    send_char(c, -1, unused);
                    if (c.column < COLUMNS) sent++;
                end
            end
        end
    endtask

    // Display byte receiver: random stalls, one long hold-off on request
    initial begin
        result_t want;
        int      stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (lcd_bytes_due.size() == 0) begin
                    $error("unexpected byte: is_data %0b lcd_byte %h last %0b",
                           m_tuser[0], m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = lcd_bytes_due.pop_front();
                    if (m_tuser[0] !== want.is_data) begin
                        $error("is_data: expected %0b, got %0b", want.is_data, m_tuser[0]);
                        mismatch_count++;
                    end
                    if (m_tdata !== want.lcd_byte) begin
                        $error("lcd_byte: expected %h, got %h", want.lcd_byte, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Main sequence
    initial begin
        int                phase_items  [5];
        logic [ADDR_W-1:0] phase_stride [5];
        phase_items  = '{150, 150, 100, 100, 100};
        phase_stride = '{7'd32, 7'd64, 7'd0, 7'd127, ADDR_W'($urandom_range(127))};
        for (int i = 0; i < SHADOW_DEPTH; i++) shadow_copy[i] = SPACE_CODE;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_read(STRIDE_ADDR, APB_DATA_W'(STRIDE_RESET));

        send_idle_pct = 25;
        recv_idle_pct = 67;
        foreach (script[k]) send_char(script[k].ch, script[k].n_bytes, script[k].bytes);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            send_idle_pct = (p < 2) ? 25 : (p < 4) ? 67 : 0;
            recv_idle_pct = (p < 2) ? 67 : (p < 4) ? 25 : 0;
            set_stride(phase_stride[p]);
            // last phase: hold the byte stream off while characters keep coming
            if (p == 4) hold_req = 1'b1;
            random_writes(phase_items[p]);
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("lcd_shadow_delta_writer test passed");
        end else begin
            $display("lcd_shadow_delta_writer test failed");
        end
        $finish;
    end

endmodule
